/* sv/cmfta_pkg.sv */
package cmfta_pkg;

    localparam int DEF_MAX_FACE_SIZE = 4096;
    localparam int DEF_DIR_BITS      = 16;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAPS_LOADED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FACE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FACE_HEIGHT = 2'd2;

    typedef enum logic [2:0] {
        FACE_NEGX = 3'd0,
        FACE_NEGY = 3'd1,
        FACE_NEGZ = 3'd2,
        FACE_POSX = 3'd3,
        FACE_POSY = 3'd4,
        FACE_POSZ = 3'd5
    } t_face;

    typedef struct packed {
        logic  valid;
        logic  hit;
        t_face face;
    } t_ctl;

endpackage

/* sv/cmfta_front.sv */
module cmfta_front
    import cmfta_pkg::*;
#(
    parameter int DW = DEF_DIR_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic          i_loaded,
    input  logic [DW-1:0] i_dir_x,
    input  logic [DW-1:0] i_dir_y,
    input  logic [DW-1:0] i_dir_z,
    output t_ctl          o_ctl,
    output logic [DW:0]   o_am_x,
    output logic [DW:0]   o_am_y,
    output logic [DW-1:0] o_mag
);

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    logic [DW-1:0] mx, my, mz, m01, m;
    logic          sel_y, sel_z, sign_major;
    t_axis         axis;
    t_face         face;
    logic signed [DW:0]   sx, sy, sz, a, b;
    logic signed [DW+1:0] sum_a, sum_b, m_ext;

    t_ctl          r_ctl;
    logic [DW:0]   r_am_x, r_am_y;
    logic [DW-1:0] r_mag;

    always_comb begin
        mx = i_dir_x[DW-1] ? (~i_dir_x + DW'(1)) : i_dir_x;
        my = i_dir_y[DW-1] ? (~i_dir_y + DW'(1)) : i_dir_y;
        mz = i_dir_z[DW-1] ? (~i_dir_z + DW'(1)) : i_dir_z;
        sel_y = my > mx;
        m01   = sel_y ? my : mx;
        sel_z = mz > m01;
        m     = sel_z ? mz : m01;
        if (sel_z) begin
            axis       = AXIS_Z;
            sign_major = i_dir_z[DW-1];
        end else if (sel_y) begin
            axis       = AXIS_Y;
            sign_major = i_dir_y[DW-1];
        end else begin
            axis       = AXIS_X;
            sign_major = i_dir_x[DW-1];
        end
    end

    always_comb begin
        case (axis)
            AXIS_X:  face = sign_major ? FACE_NEGX : FACE_POSX;
            AXIS_Y:  face = sign_major ? FACE_NEGY : FACE_POSY;
            AXIS_Z:  face = sign_major ? FACE_NEGZ : FACE_POSZ;
            default: face = FACE_NEGX;
        endcase
    end

    always_comb begin
        sx = $signed({i_dir_x[DW-1], i_dir_x});
        sy = $signed({i_dir_y[DW-1], i_dir_y});
        sz = $signed({i_dir_z[DW-1], i_dir_z});
        case (face)
            FACE_NEGX: begin a = sz;  b = -sy; end
            FACE_NEGY: begin a = sx;  b = -sz; end
            FACE_NEGZ: begin a = sx;  b = sy;  end
            FACE_POSX: begin a = -sz; b = -sy; end
            FACE_POSY: begin a = sx;  b = sz;  end
            default:   begin a = sx;  b = -sy; end
        endcase
        m_ext = $signed({2'b00, m});
        sum_a = (DW+2)'(a) + m_ext;
        sum_b = (DW+2)'(b) + m_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid <= i_valid;
        end
        if (i_en) begin
            r_ctl.hit  <= i_loaded && (m != '0);
            r_ctl.face <= face;
            r_am_x     <= sum_a[DW:0];
            r_am_y     <= sum_b[DW:0];
            r_mag      <= m;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_am_x = r_am_x;
    assign o_am_y = r_am_y;
    assign o_mag  = r_mag;

endmodule

/* sv/cmfta_mul.sv */
module cmfta_mul
    import cmfta_pkg::*;
#(
    parameter int DW            = DEF_DIR_BITS,
    parameter int MAX_FACE_SIZE = DEF_MAX_FACE_SIZE,
    parameter int SZ_W          = 13,
    parameter int NW            = 30
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_rst_n,
    input  t_ctl             i_ctl,
    input  logic [DW:0]      i_am_x,
    input  logic [DW:0]      i_am_y,
    input  logic [DW-1:0]    i_mag,
    input  logic [CFG_W-1:0] i_width,
    input  logic [CFG_W-1:0] i_height,
    output t_ctl             o_ctl,
    output logic [NW-1:0]    o_num_x,
    output logic [NW-1:0]    o_num_y,
    output logic [DW:0]      o_den,
    output logic [SZ_W-1:0]  o_size_x,
    output logic [SZ_W-1:0]  o_size_y
);

    function automatic logic [SZ_W-1:0] eff_size(input logic [CFG_W-1:0] r);
        logic [SZ_W-1:0] s;
        if (r == '0) begin
            s = SZ_W'(1);
        end else if (32'(r) > MAX_FACE_SIZE) begin
            s = SZ_W'(MAX_FACE_SIZE);
        end else begin
            s = SZ_W'(r);
        end
        return s;
    endfunction

    logic [SZ_W-1:0] size_x, size_y;

    t_ctl            r_ctl;
    logic [NW-1:0]   r_num_x, r_num_y;
    logic [DW:0]     r_den;
    logic [SZ_W-1:0] r_size_x, r_size_y;

    assign size_x = eff_size(i_width);
    assign size_y = eff_size(i_height);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid <= i_ctl.valid;
        end
        if (i_en) begin
            r_ctl.hit  <= i_ctl.hit;
            r_ctl.face <= i_ctl.face;
            r_num_x    <= NW'(i_am_x) * NW'(size_x);
            r_num_y    <= NW'(i_am_y) * NW'(size_y);
            r_den      <= {i_mag, 1'b0};
            r_size_x   <= size_x;
            r_size_y   <= size_y;
        end
    end

    assign o_ctl    = r_ctl;
    assign o_num_x  = r_num_x;
    assign o_num_y  = r_num_y;
    assign o_den    = r_den;
    assign o_size_x = r_size_x;
    assign o_size_y = r_size_y;

endmodule

/* sv/cmfta_div_cell.sv */
module cmfta_div_cell
    import cmfta_pkg::*;
#(
    parameter int NW    = 30,
    parameter int DEN_W = 17,
    parameter int QW    = 13,
    parameter int BIT   = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_ctl             i_ctl,
    input  logic [NW-1:0]    i_rem_x,
    input  logic [NW-1:0]    i_rem_y,
    input  logic [QW-1:0]    i_q_x,
    input  logic [QW-1:0]    i_q_y,
    input  logic [DEN_W-1:0] i_den,
    input  logic [QW-1:0]    i_size_x,
    input  logic [QW-1:0]    i_size_y,
    output t_ctl             o_ctl,
    output logic [NW-1:0]    o_rem_x,
    output logic [NW-1:0]    o_rem_y,
    output logic [QW-1:0]    o_q_x,
    output logic [QW-1:0]    o_q_y,
    output logic [DEN_W-1:0] o_den,
    output logic [QW-1:0]    o_size_x,
    output logic [QW-1:0]    o_size_y
);

    logic [NW-1:0] dsh;
    logic          ge_x, ge_y;

    t_ctl             r_ctl;
    logic [NW-1:0]    r_rem_x, r_rem_y;
    logic [QW-1:0]    r_q_x, r_q_y;
    logic [DEN_W-1:0] r_den;
    logic [QW-1:0]    r_size_x, r_size_y;

    // one restoring step: quotient bit BIT for both coordinates
    assign dsh  = NW'(i_den) << BIT;
    assign ge_x = i_rem_x >= dsh;
    assign ge_y = i_rem_y >= dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid <= i_ctl.valid;
        end
        if (i_en) begin
            r_ctl.hit  <= i_ctl.hit;
            r_ctl.face <= i_ctl.face;
            r_rem_x    <= ge_x ? (i_rem_x - dsh) : i_rem_x;
            r_rem_y    <= ge_y ? (i_rem_y - dsh) : i_rem_y;
            r_q_x      <= i_q_x | (QW'(ge_x) << BIT);
            r_q_y      <= i_q_y | (QW'(ge_y) << BIT);
            r_den      <= i_den;
            r_size_x   <= i_size_x;
            r_size_y   <= i_size_y;
        end
    end

    assign o_ctl    = r_ctl;
    assign o_rem_x  = r_rem_x;
    assign o_rem_y  = r_rem_y;
    assign o_q_x    = r_q_x;
    assign o_q_y    = r_q_y;
    assign o_den    = r_den;
    assign o_size_x = r_size_x;
    assign o_size_y = r_size_y;

endmodule

/* sv/cubemap_face_texel_address_top.sv */
// Cube map face select and texel addressing. Each direction transfer yields
// exactly one result transfer, in order, at one transfer per clock while
// s_axis_tready is high. The pipeline registers are one for major-axis pick
// and projection, one for the size multiply, one divider cell per quotient
// bit, and the output register. A skid register behind the output absorbs a
// result when the sink stalls; input tready drops only while that skid
// register is full. Write the config registers only while the pipeline is
// empty. m_axis_tuser is the hit flag; on a miss the face and texel fields
// are zero.
module cubemap_face_texel_address_top
    import cmfta_pkg::*;
#(
    parameter int MAX_FACE_SIZE = DEF_MAX_FACE_SIZE,
    parameter int DIR_BITS      = DEF_DIR_BITS
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // dir_x, dir_y, dir_z
    input  logic [((3*DIR_BITS+7)/8)*8-1:0]         s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // face, texel_x, texel_y
    output logic [((3+2*((MAX_FACE_SIZE>1)?$clog2(MAX_FACE_SIZE):1)+7)/8)*8-1:0]
                                                    m_axis_tdata,
    // hit
    output logic                                    m_axis_tuser,
    input  logic                                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                    i_cfg_idx,
    input  logic [CFG_W-1:0]                        i_cfg_data
);

    localparam int DW    = DIR_BITS;
    localparam int SZ_W  = $clog2(MAX_FACE_SIZE+1);
    localparam int QW    = SZ_W;
    localparam int DEN_W = DW + 1;
    localparam int NW    = DW + 1 + SZ_W;
    localparam int TW    = (MAX_FACE_SIZE > 1) ? $clog2(MAX_FACE_SIZE) : 1;
    localparam int ODW   = ((3 + 2*TW + 7) / 8) * 8;

    logic             r_maps_loaded;
    logic [CFG_W-1:0] r_face_width, r_face_height;

    logic en;

    t_ctl          f_ctl;
    logic [DW:0]   f_am_x, f_am_y;
    logic [DW-1:0] f_mag;

    t_ctl             c_ctl    [0:QW];
    logic [NW-1:0]    c_rem_x  [0:QW];
    logic [NW-1:0]    c_rem_y  [0:QW];
    logic [QW-1:0]    c_q_x    [0:QW];
    logic [QW-1:0]    c_q_y    [0:QW];
    logic [DEN_W-1:0] c_den    [0:QW];
    logic [QW-1:0]    c_size_x [0:QW];
    logic [QW-1:0]    c_size_y [0:QW];

    logic [QW-1:0]  tx_c, ty_c;
    logic [ODW-1:0] n_data;
    logic           n_user;
    logic           push, pop;

    logic           r_out_valid, r_skid_valid;
    logic [ODW-1:0] r_out_data, r_skid_data;
    logic           r_out_user, r_skid_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_maps_loaded <= 1'b0;
            r_face_width  <= CFG_W'(1);
            r_face_height <= CFG_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAPS_LOADED: r_maps_loaded <= i_cfg_data[0];
                CFG_FACE_WIDTH:  r_face_width  <= i_cfg_data;
                CFG_FACE_HEIGHT: r_face_height <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    assign en            = !r_skid_valid;
    assign s_axis_tready = en;

    cmfta_front #(
        .DW (DW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (s_axis_tvalid),
        .i_loaded (r_maps_loaded),
        .i_dir_x  (s_axis_tdata[DW-1:0]),
        .i_dir_y  (s_axis_tdata[2*DW-1:DW]),
        .i_dir_z  (s_axis_tdata[3*DW-1:2*DW]),
        .o_ctl    (f_ctl),
        .o_am_x   (f_am_x),
        .o_am_y   (f_am_y),
        .o_mag    (f_mag)
    );

    cmfta_mul #(
        .DW            (DW),
        .MAX_FACE_SIZE (MAX_FACE_SIZE),
        .SZ_W          (SZ_W),
        .NW            (NW)
    ) u_mul (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_rst_n  (i_rst_n),
        .i_ctl    (f_ctl),
        .i_am_x   (f_am_x),
        .i_am_y   (f_am_y),
        .i_mag    (f_mag),
        .i_width  (r_face_width),
        .i_height (r_face_height),
        .o_ctl    (c_ctl[0]),
        .o_num_x  (c_rem_x[0]),
        .o_num_y  (c_rem_y[0]),
        .o_den    (c_den[0]),
        .o_size_x (c_size_x[0]),
        .o_size_y (c_size_y[0])
    );

    assign c_q_x[0] = '0;
    assign c_q_y[0] = '0;

    for (genvar k = 0; k < QW; k++) begin : g_cell
        cmfta_div_cell #(
            .NW    (NW),
            .DEN_W (DEN_W),
            .QW    (QW),
            .BIT   (QW - 1 - k)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_ctl    (c_ctl[k]),
            .i_rem_x  (c_rem_x[k]),
            .i_rem_y  (c_rem_y[k]),
            .i_q_x    (c_q_x[k]),
            .i_q_y    (c_q_y[k]),
            .i_den    (c_den[k]),
            .i_size_x (c_size_x[k]),
            .i_size_y (c_size_y[k]),
            .o_ctl    (c_ctl[k+1]),
            .o_rem_x  (c_rem_x[k+1]),
            .o_rem_y  (c_rem_y[k+1]),
            .o_q_x    (c_q_x[k+1]),
            .o_q_y    (c_q_y[k+1]),
            .o_den    (c_den[k+1]),
            .o_size_x (c_size_x[k+1]),
            .o_size_y (c_size_y[k+1])
        );
    end

    // clamp the far edge, zero everything on a miss
    always_comb begin
        tx_c = (c_q_x[QW] >= c_size_x[QW]) ? (c_size_x[QW] - QW'(1)) : c_q_x[QW];
        ty_c = (c_q_y[QW] >= c_size_y[QW]) ? (c_size_y[QW] - QW'(1)) : c_q_y[QW];
        n_user = c_ctl[QW].hit;
        if (c_ctl[QW].hit) begin
            n_data = ODW'({TW'(ty_c), TW'(tx_c), c_ctl[QW].face});
        end else begin
            n_data = '0;
        end
    end

    assign push = en && c_ctl[QW].valid;
    assign pop  = r_out_valid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out_data   <= r_skid_data;
                r_out_user   <= r_skid_user;
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid || pop) begin
                r_out_data  <= n_data;
                r_out_user  <= n_user;
                r_out_valid <= 1'b1;
            end else begin
                r_skid_data  <= n_data;
                r_skid_user  <= n_user;
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule
